// ----- hdl/bia_pkg.sv -----
// bitmap id allocator: shared types, widths and the lowest-clear-bit search
// no dependencies
package bia_pkg;

  localparam int ID_W    = 12;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;
  localparam int WADDR_W = 6;
  localparam int CNT_W   = 13;
  localparam int REM_W   = 7;

  localparam logic [ID_W-1:0]  MAX_GRANTS    = 12'd64;
  localparam logic [CNT_W-1:0] COUNT_CEILING = 13'd4096;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
  } mem_rd_t;

  // lowest clear bit, 63 when bits 0 to 62 are all set
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] b;
    b = BIT_W'(WORD_W - 1);
    for (int i = WORD_W - 2; i >= 0; i--) begin
      if (!w[i]) begin
        b = BIT_W'(i);
      end
    end
    return b;
  endfunction

endpackage

// ----- hdl/bia_in_if.sv -----
// bitmap id allocator: request channel
// depends on bia_pkg
interface bia_in_if
  import bia_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [ID_W-1:0] req_count;
  logic [ID_W-1:0] free_id;

  modport source (output valid, cmd, req_count, free_id, input ready);
  modport sink   (input valid, cmd, req_count, free_id, output ready);
endinterface

// ----- hdl/bia_out_if.sv -----
// bitmap id allocator: result channel
// depends on bia_pkg
interface bia_out_if
  import bia_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            ok;
  logic            has_id;
  logic [ID_W-1:0] granted_id;
  logic            last;

  modport source (output valid, ok, has_id, granted_id, last, input ready);
  modport sink   (input valid, ok, has_id, granted_id, last, output ready);
endinterface

// ----- hdl/bia_bitmap_mem.sv -----
// bitmap id allocator: bitmap word memory, one write and one registered read port
// per-word valid flops make unwritten words read as all free; depends on bia_pkg
module bia_bitmap_mem
  import bia_pkg::*;
#(
  parameter int WORD_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_wr_t           wr_i,
  input  mem_rd_t           rd_i,
  output logic [WORD_W-1:0] rd_data_o
);

  localparam int IDX_W = $clog2(WORD_COUNT);

  logic [WORD_W-1:0]     mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] valid_q;
  logic [WORD_W-1:0]     rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[IDX_W-1:0]] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_i.en) begin
        rvalid_q <= valid_q[rd_i.addr[IDX_W-1:0]];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- hdl/bitmap_id_allocator_unit.sv -----
// bitmap id allocator: top level, request sequencer around the bitmap memory
// depends on bia_pkg, bia_in_if, bia_out_if, bia_bitmap_mem
//
//   channel  dir  fields                             accepted when
//   in_i     in   cmd, req_count, free_id            valid && ready
//   out_o    out  ok, has_id, granted_id, last       valid && ready
//
// refused or empty allocates and out-of-range frees: one result, given straight from idle
// free: read, then modify, write back and result
// allocate of n ids: load a word, grant its lowest clear bits in turn, move past each full word
// reset is immediate: per-word valid flops stand in for a clearing pass
// a stalled result holds the sequencer; a new item is taken once the sequencer is idle and the result has space
module bitmap_id_allocator_unit
  import bia_pkg::*;
#(
  parameter int WORD_COUNT = 64,
  parameter int ID_BUDGET  = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bia_in_if.sink   in_i,
  bia_out_if.source out_o
);

  localparam int PTR_W = $clog2(WORD_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,
    S_LOAD,
    S_GRANT
  } state_e;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d, ptr_next;
  logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]   avail_q, avail_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [WADDR_W-1:0] fword_q, fword_d;
  logic [BIT_W-1:0]   fbit_q, fbit_d;
  logic [WORD_W-1:0]  wd_q, wd_d;

  logic               out_valid_q, out_valid_d;
  logic               out_ok_q, out_ok_d;
  logic               out_has_q, out_has_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic               out_last_q, out_last_d;

  mem_wr_t            wr;
  mem_rd_t            rd;
  logic [WORD_W-1:0]  rd_word;
  logic               out_space;
  logic               accept;
  logic [BIT_W-1:0]   gbit;

  bia_bitmap_mem #(
    .WORD_COUNT(WORD_COUNT)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_i     (rd),
    .rd_data_o(rd_word)
  );

  assign out_space  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_space;
  assign accept     = in_i.valid && in_i.ready;
  assign ptr_next   = (ptr_q == PTR_W'(WORD_COUNT - 1)) ? '0 : ptr_q + 1'b1;
  assign gbit       = lowest_clear(wd_q);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    free_cnt_d  = free_cnt_q;
    avail_d     = avail_q;
    rem_d       = rem_q;
    fword_d     = fword_q;
    fbit_d      = fbit_q;
    wd_d        = wd_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_ok_d    = out_ok_q;
    out_has_d   = out_has_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    wr          = '0;
    rd          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_has_d  = 1'b0;
          out_id_d   = '0;
          out_last_d = 1'b1;
          if (in_i.cmd) begin
            if ({1'b0, in_i.free_id[ID_W-1:BIT_W]} >= (WADDR_W + 1)'(WORD_COUNT)) begin
              out_valid_d = 1'b1;
              out_ok_d    = 1'b0;
            end else begin
              rd.en   = 1'b1;
              rd.addr = in_i.free_id[ID_W-1:BIT_W];
              fword_d = in_i.free_id[ID_W-1:BIT_W];
              fbit_d  = in_i.free_id[BIT_W-1:0];
              state_d = S_FREE;
            end
          end else if (in_i.req_count == '0) begin
            out_valid_d = 1'b1;
            out_ok_d    = 1'b1;
          end else if (free_cnt_q < {1'b0, in_i.req_count} ||
                       in_i.req_count > MAX_GRANTS ||
                       avail_q < {1'b0, in_i.req_count}) begin
            out_valid_d = 1'b1;
            out_ok_d    = 1'b0;
          end else begin
            rem_d   = in_i.req_count[REM_W-1:0];
            rd.en   = 1'b1;
            rd.addr = WADDR_W'(ptr_q);
            state_d = S_LOAD;
          end
        end
      end
      S_FREE: begin
        if (out_space) begin
          wr.en   = 1'b1;
          wr.addr = fword_q;
          wr.data = rd_word & ~(WORD_W'(1) << fbit_q);
          if (rd_word[fbit_q]) begin
            avail_d = avail_q + 1'b1;
          end
          if (free_cnt_q < COUNT_CEILING) begin
            free_cnt_d = free_cnt_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_ok_d    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_LOAD: begin
        wd_d    = rd_word;
        state_d = S_GRANT;
      end
      S_GRANT: begin
        if (&wd_q) begin
          ptr_d   = ptr_next;
          rd.en   = 1'b1;
          rd.addr = WADDR_W'(ptr_next);
          state_d = S_LOAD;
        end else if (out_space) begin
          wd_d        = wd_q | (WORD_W'(1) << gbit);
          wr.en       = 1'b1;
          wr.addr     = WADDR_W'(ptr_q);
          wr.data     = wd_d;
          avail_d     = avail_q - 1'b1;
          free_cnt_d  = free_cnt_q - 1'b1;
          rem_d       = rem_q - 1'b1;
          out_valid_d = 1'b1;
          out_ok_d    = 1'b1;
          out_has_d   = 1'b1;
          out_id_d    = {WADDR_W'(ptr_q), gbit};
          out_last_d  = (rem_q == REM_W'(1));
          if (rem_q == REM_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      free_cnt_q  <= CNT_W'(ID_BUDGET);
      avail_q     <= CNT_W'(WORD_COUNT * WORD_W);
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      free_cnt_q  <= free_cnt_d;
      avail_q     <= avail_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fword_q    <= fword_d;
    fbit_q     <= fbit_d;
    wd_q       <= wd_d;
    out_ok_q   <= out_ok_d;
    out_has_q  <= out_has_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ok         = out_ok_q;
  assign out_o.has_id     = out_has_q;
  assign out_o.granted_id = out_id_q;
  assign out_o.last       = out_last_q;

endmodule

// ----- hdl/bia_checker.sv -----
// bitmap id allocator: port checker and its bind to the top level
// depends on bia_pkg and bitmap_id_allocator_unit
module bia_checker
  import bia_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic            out_ok_i,
  input logic            out_has_id_i,
  input logic [ID_W-1:0] out_granted_id_i,
  input logic            out_last_i
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // only an accepted request carries an id
  a_id_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_has_id_i |-> out_ok_i)
    else $error("id granted on a refused request");

  // a refusal is a single closing item with no id
  a_refuse_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i |-> out_last_i && !out_has_id_i)
    else $error("refusal not a lone last item");

  // no id, zero id field
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_has_id_i |-> out_granted_id_i == '0)
    else $error("id field set without an id");

endmodule

bind bitmap_id_allocator_unit bia_checker u_bia_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_ok_i        (out_o.ok),
  .out_has_id_i    (out_o.has_id),
  .out_granted_id_i(out_o.granted_id),
  .out_last_i      (out_o.last)
);
